// ===== rtl/lbs_pkg.sv =====
// Shared types and constants for the leaky bounded stack.
package lbs_pkg;

  localparam int VALUE_W    = 32;
  localparam int DEPTH_W    = 7;
  localparam int CAP_W      = 7;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [DEPTH_W-1:0]    depth_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  localparam cfg_idx_t CFG_CAPACITY    = 2'd0;
  localparam cfg_idx_t CFG_LEAK_PERIOD = 2'd1;

endpackage

// ===== rtl/lbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/leaky_bounded_stack.sv =====
// Top level of the leaky bounded stack: control, ring pointers and result register.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_command, in_push_value
//   out_     output     out_valid / out_ready depth, top value, top valid, dropped, leaked
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A pop that leaves entries reads its new top from the RAM; other items need no RAM read.
// Reset is synchronous: it clears the pointers, counters, leak period and busy/valid flags,
// loads the capacity with CAP_RESET, and leaves the result registers and the RAM uncleared.
// A new item is taken while the previous result is being transferred on the output.
// The configuration port is always ready.
module leaky_bounded_stack #(
  parameter int MAX_DEPTH = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lbs_pkg::cmd_t       in_command,
  input  lbs_pkg::value_t     in_push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output lbs_pkg::depth_t     out_depth,
  output lbs_pkg::value_t     out_top_value,
  output logic                out_top_valid,
  output logic                out_push_dropped,
  output logic                out_leaked,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lbs_pkg::cfg_idx_t   cfg_index,
  input  lbs_pkg::cfg_data_t  cfg_data
);

  import lbs_pkg::*;

  localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int EXT_W = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_DEPTH);

  logic [CAP_W-1:0]     cap_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [CNT_W-1:0]     count_r;
  logic [PTR_W-1:0]     bottom_r;
  logic [PERIOD_W-1:0]  opcnt_r;
  logic [WORD_BITS-1:0] top_r;
  logic                 busy_r;
  logic                 out_valid_r;
  depth_t               out_depth_r;
  value_t               out_top_r;
  logic                 out_top_valid_r;
  logic                 out_dropped_r;
  logic                 out_leaked_r;

  logic [CNT_W-1:0]     count_nxt;
  logic [PTR_W-1:0]     bottom_nxt;
  logic [PERIOD_W-1:0]  opcnt_nxt;
  logic                 busy_nxt;
  logic                 out_valid_nxt;

  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_eff;
  logic                 accept;
  logic                 is_push;
  logic                 push_ok;
  logic                 pop_ok;
  logic                 drop;
  logic [CNT_W-1:0]     count_op;
  logic [PERIOD_W-1:0]  opcnt_inc;
  logic                 fire;
  logic                 leak;
  logic                 need_read;
  logic [PTR_W-1:0]     wr_addr;
  logic [PTR_W-1:0]     rd_addr;
  logic [PTR_W-1:0]     bottom_inc;
  logic signed [EXT_W-1:0] wr_wide;
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] top_sel;
  logic [WORD_BITS-1:0] ram_rdata;
  logic signed [EXT_W-1:0] top_sel_wide;
  logic signed [EXT_W-1:0] rd_wide;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PTR_W+1)'(MAX_DEPTH)) begin
      s = s - (PTR_W+1)'(MAX_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = !busy_r && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  assign cap_ext = CMP_W'(cap_r);
  assign cap_eff = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;

  assign is_push = (in_command == CMD_PUSH);
  assign push_ok = is_push && (CMP_W'(count_r) < cap_eff);
  assign drop    = is_push && !push_ok;
  assign pop_ok  = !is_push && (count_r != '0);

  always_comb begin
    if (push_ok) begin
      count_op = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_op = count_r - CNT_W'(1);
    end else begin
      count_op = count_r;
    end
  end

  assign opcnt_inc = opcnt_r + PERIOD_W'(1);
  assign fire      = (period_r != '0) && (opcnt_inc >= period_r);
  assign leak      = fire && (count_op != '0);
  assign need_read = pop_ok && (count_nxt != '0);

  assign wr_addr    = ring_add(bottom_r, count_r[PTR_W-1:0]);
  assign rd_addr    = ring_add(bottom_r, PTR_W'(count_r - CNT_W'(2)));
  assign bottom_inc = ring_add(bottom_r, PTR_W'(1));

  assign wr_wide = EXT_W'(in_push_value);
  assign wr_word = wr_wide[WORD_BITS-1:0];
  assign top_sel = push_ok ? wr_word : top_r;

  assign top_sel_wide = EXT_W'(signed'(top_sel));
  assign rd_wide      = EXT_W'(signed'(ram_rdata));

  always_comb begin
    count_nxt  = count_r;
    bottom_nxt = bottom_r;
    opcnt_nxt  = opcnt_r;
    if (accept) begin
      count_nxt = leak ? (count_op - CNT_W'(1)) : count_op;
      if (leak) begin
        bottom_nxt = bottom_inc;
      end
      if (period_r != '0) begin
        opcnt_nxt = fire ? '0 : opcnt_inc;
      end
    end
  end

  always_comb begin
    busy_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (busy_r) begin
      out_valid_nxt = 1'b1;
    end else if (accept) begin
      busy_nxt      = need_read;
      out_valid_nxt = !need_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      period_r    <= '0;
      count_r     <= '0;
      bottom_r    <= '0;
      opcnt_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      bottom_r    <= bottom_nxt;
      opcnt_r     <= opcnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY:    cap_r    <= cfg_data[CAP_W-1:0];
          CFG_LEAK_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      top_r     <= ram_rdata;
      out_top_r <= rd_wide[VALUE_W-1:0];
    end else if (accept) begin
      top_r           <= top_sel;
      out_depth_r     <= DEPTH_W'(count_nxt);
      out_top_valid_r <= (count_nxt != '0);
      out_dropped_r   <= drop;
      out_leaked_r    <= leak;
      out_top_r       <= (count_nxt != '0) ? top_sel_wide[VALUE_W-1:0] : '0;
    end
  end

  lbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && push_ok),
    .waddr (wr_addr),
    .wdata (wr_word),
    .re    (accept && need_read),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_depth        = out_depth_r;
  assign out_top_value    = out_top_r;
  assign out_top_valid    = out_top_valid_r;
  assign out_push_dropped = out_dropped_r;
  assign out_leaked       = out_leaked_r;

endmodule

// ===== rtl/lbs_chk.sv =====
// Port-level checker for the leaky bounded stack and its bind statement.
module lbs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lbs_pkg::cmd_t       in_command,
  input logic                out_valid,
  input logic                out_ready,
  input lbs_pkg::depth_t     out_depth,
  input lbs_pkg::value_t     out_top_value,
  input logic                out_top_valid,
  input logic                out_push_dropped
);

  import lbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_depth) && $stable(out_top_value))
    else $error("result changed while stalled");

  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_depth != '0)))
    else $error("top valid does not match depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_top_valid |-> (out_top_value == '0))
    else $error("empty stack shows a nonzero top");

  a_pop_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready && (in_command == CMD_POP)
      |=> !out_valid || !out_push_dropped)
    else $error("pop reported as dropped push");

endmodule

bind leaky_bounded_stack lbs_chk u_lbs_chk (.*);
